// File: rtl/bgc_pkg.sv
// bgc_pkg: shared types and constants for the button gesture classifier.
// Used by bgc_core, bgc_out_seq and button_gesture_classifier.
`timescale 1ns / 1ps
package bgc_pkg;

    // Default width of the saturating age counters
    localparam int COUNTER_BITS_DEF = 16;

    // Configuration port geometry
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] LONG_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_RST = 16'd300;
    localparam logic [CFG_W-1:0] ARM_RST    = 16'd3000;

    // Events slots per tick and number of candidate events per tick
    localparam int MAX_EV = 3;
    localparam int NUM_CAND = 7;

    // Event codes as they leave the block
    typedef enum logic [2:0] {
        EV_PRESSED   = 3'd0,
        EV_RELEASED  = 3'd1,
        EV_LONG      = 3'd2,
        EV_DOUBLE    = 3'd3,
        EV_ARMED     = 3'd4,
        EV_CANCELLED = 3'd5
    } ev_code_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS  = 2'd0,
        CFG_DOUBLE_PRESS = 2'd1,
        CFG_ARM_WINDOW  = 2'd2,
        CFG_ACTIVE_LOW  = 2'd3
    } cfg_idx_t;

    // Candidate events in emission order: timeout cancel, press, long,
    // double-press cancel, double, armed, release
    localparam ev_code_t CAND_CODE [NUM_CAND] = '{
        EV_CANCELLED, EV_PRESSED, EV_LONG, EV_CANCELLED,
        EV_DOUBLE, EV_ARMED, EV_RELEASED
    };

    // Events produced by one tick, handed from core to output sequencer
    typedef struct packed {
        logic                   valid;
        logic [1:0]             count;
        logic [MAX_EV-1:0][2:0] code;
    } bgc_events_t;

endpackage

// File: rtl/bgc_core.sv
// bgc_core: input register, configuration registers, gesture state and the
// per-tick event logic. Depends on bgc_pkg.
`timescale 1ns / 1ps
module bgc_core #(
    parameter int COUNTER_BITS = bgc_pkg::COUNTER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgc_pkg::CFG_W-1:0]     cfg_data,
    // tick stream
    input  logic                          tick_valid,
    output logic                          tick_ready,
    input  logic                          tick_pin,
    // events to sequencer
    output bgc_pkg::bgc_events_t          ev,
    input  logic                          ev_ready
);
    import bgc_pkg::*;

    localparam int CMP_W = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;

    // Configuration registers
    logic [CFG_W-1:0] long_ticks_reg;
    logic [CFG_W-1:0] double_ticks_reg;
    logic [CFG_W-1:0] arm_ticks_reg;
    logic             active_low_reg;

    // Input register
    logic in_valid_reg;
    logic pin_reg;

    // Gesture state
    logic held_reg, long_reg, first_tap_reg, cand_reg, armed_reg;
    logic held_next, long_next, first_tap_next, cand_next, armed_next;
    logic [COUNTER_BITS-1:0] hold_age_reg, release_age_reg, arm_age_reg;
    logic [COUNTER_BITS-1:0] hold_age_next, release_age_next, arm_age_next;

    logic                    advance;
    logic                    pressed;
    logic [COUNTER_BITS-1:0] hold_bump, release_bump, arm_bump;
    logic                    hold_ge, release_ge, arm_ge;
    logic                    first_tap_kept, timeout, armed_kept;
    logic [NUM_CAND-1:0]     fire;
    logic [1:0]              n_ev;
    logic [MAX_EV-1:0][2:0]  slot;

    assign advance    = in_valid_reg & ev_ready;
    assign tick_ready = ~in_valid_reg | ev_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_ticks_reg   <= LONG_RST;
            double_ticks_reg <= DOUBLE_RST;
            arm_ticks_reg    <= ARM_RST;
            active_low_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LONG_PRESS:   long_ticks_reg   <= cfg_data;
                CFG_DOUBLE_PRESS: double_ticks_reg <= cfg_data;
                CFG_ARM_WINDOW:   arm_ticks_reg    <= cfg_data;
                CFG_ACTIVE_LOW:   active_low_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Input register: holds one tick until the sequencer can take its events
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (tick_ready)
            in_valid_reg <= tick_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick_ready && tick_valid)
            pin_reg <= tick_pin;
    end

    // Saturating ages and threshold compares
    assign pressed      = active_low_reg ? ~pin_reg : pin_reg;
    assign hold_bump    = (&hold_age_reg) ? hold_age_reg : hold_age_reg + 1'b1;
    assign release_bump = (&release_age_reg) ? release_age_reg : release_age_reg + 1'b1;
    assign arm_bump     = (&arm_age_reg) ? arm_age_reg : arm_age_reg + 1'b1;
    assign hold_ge      = CMP_W'(hold_bump) >= CMP_W'(long_ticks_reg);
    assign release_ge   = CMP_W'(release_bump) >= CMP_W'(double_ticks_reg);
    assign arm_ge       = CMP_W'(arm_bump) >= CMP_W'(arm_ticks_reg);

    // Window expiry and arm timeout come before the edge handling
    assign first_tap_kept = first_tap_reg & ~(~pressed & release_ge);
    assign timeout        = armed_reg & ~pressed & arm_ge;
    assign armed_kept     = armed_reg & ~timeout;

    // Next state and the events raised by this tick
    always_comb
    begin
        held_next        = held_reg;
        long_next        = long_reg;
        first_tap_next   = first_tap_kept;
        cand_next        = cand_reg;
        armed_next       = armed_kept;
        hold_age_next    = hold_bump;
        release_age_next = release_bump;
        arm_age_next     = arm_bump;
        fire             = '0;
        fire[0]          = timeout;

        if (pressed && !held_reg)
        begin
            cand_next     = first_tap_kept & ~release_ge;
            armed_next    = 1'b0;
            hold_age_next = '0;
            held_next     = 1'b1;
            long_next     = 1'b0;
            fire[1]       = 1'b1;
        end
        else if (pressed && held_reg)
        begin
            if (!long_reg && hold_ge)
            begin
                long_next      = 1'b1;
                cand_next      = 1'b0;
                first_tap_next = 1'b0;
                fire[2]        = 1'b1;
            end
        end
        else if (!pressed && held_reg)
        begin
            held_next = 1'b0;
            cand_next = 1'b0;
            fire[6]   = 1'b1;
            if (!long_reg)
            begin
                if (cand_reg)
                begin
                    first_tap_next = 1'b0;
                    fire[3]        = 1'b1;
                    fire[4]        = 1'b1;
                end
                else
                begin
                    first_tap_next   = 1'b1;
                    release_age_next = '0;
                    if (!armed_kept)
                    begin
                        armed_next   = 1'b1;
                        arm_age_next = '0;
                        fire[5]      = 1'b1;
                    end
                end
            end
        end
    end

    // Pack raised events into slots in order, at most three
    always_comb
    begin
        n_ev = '0;
        slot = '0;
        for (int i = 0; i < NUM_CAND; i++)
        begin
            if (fire[i] && n_ev != 2'(MAX_EV))
            begin
                slot[n_ev] = CAND_CODE[i];
                n_ev       = n_ev + 1'b1;
            end
        end
    end

    assign ev.valid = in_valid_reg;
    assign ev.count = n_ev;
    assign ev.code  = slot;

    // State update, once per tick handed on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= 1'b0;
            long_reg        <= 1'b0;
            first_tap_reg   <= 1'b0;
            cand_reg        <= 1'b0;
            armed_reg       <= 1'b0;
            hold_age_reg    <= '0;
            release_age_reg <= '0;
            arm_age_reg     <= '0;
        end
        else if (advance)
        begin
            held_reg        <= held_next;
            long_reg        <= long_next;
            first_tap_reg   <= first_tap_next;
            cand_reg        <= cand_next;
            armed_reg       <= armed_next;
            hold_age_reg    <= hold_age_next;
            release_age_reg <= release_age_next;
            arm_age_reg     <= arm_age_next;
        end
    end

    // A double-press candidate only exists while the button is held
    a_cand_held: assert property (@(posedge clk) disable iff (!rst_n)
        cand_reg |-> held_reg)
        else $error("double-press candidate without hold");

    // Power-off arming is only live while released
    a_armed_released: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> !held_reg)
        else $error("power-off armed while held");

    // A press edge always yields a pressed event in the slots
    a_press_event: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && pressed && !held_reg) |-> (ev.count != 2'd0))
        else $error("press edge produced no event");

endmodule

// File: rtl/bgc_out_seq.sv
// bgc_out_seq: result register holding the events of one tick and sending
// them one transfer at a time. Depends on bgc_pkg.
`timescale 1ns / 1ps
module bgc_out_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    // events from core
    input  bgc_pkg::bgc_events_t ev,
    output logic                 ev_ready,
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [2:0] event_code, [7:3] zero
    output logic                 m_tlast    // last_event
);
    import bgc_pkg::*;

    logic [1:0]             cnt_reg;
    logic [MAX_EV-1:0][2:0] slot_reg;
    logic                   pop;
    logic                   load;

    assign pop      = m_tvalid & m_tready;
    assign ev_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign load     = ev.valid & ev_ready;

    // Event count of the tick being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load)
            cnt_reg <= ev.count;
        else if (pop)
            cnt_reg <= cnt_reg - 1'b1;
    end

    // Slot shift register, head at slot 0
    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= ev.code;
        else if (pop)
            slot_reg <= {3'b000, slot_reg[MAX_EV-1:1]};
    end

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = {5'b00000, slot_reg[0]};
    assign m_tlast  = cnt_reg == 2'd1;

    // A tick is only loaded over a finished or finishing one
    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("events loaded over pending events");

    // The loaded count arrives intact
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> cnt_reg == $past(ev.count))
        else $error("event count lost on load");

endmodule

// File: rtl/button_gesture_classifier.sv
// button_gesture_classifier: top level, one debounced pin sample per tick in,
// gesture events out. Depends on bgc_pkg, bgc_core and bgc_out_seq.
//
//  channel | signals                          | payload
//  --------+----------------------------------+---------------------------------
//  ticks   | s_tvalid / s_tready / s_tdata    | [0] pin_level
//  events  | m_tvalid / m_tready / m_tdata,   | [2:0] event_code;
//          | m_tlast                          | tlast = last_event
//  config  | cfg_we / cfg_index / cfg_data    | 0 long, 1 double, 2 arm, 3 polarity
//
// A tick is held in the input register; its events (0 to 3) are loaded
// into the result register and leave one per cycle while m_tready is
// high.
// The next tick is taken while the last event of the previous one leaves.
// Reset clears the gesture state and loads the default thresholds.
// Stalls on m_tready propagate back to s_tready through the result register.
`timescale 1ns / 1ps
module button_gesture_classifier #(
    parameter int COUNTER_BITS = bgc_pkg::COUNTER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] pin_level, [7:1] unused
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [2:0] event_code, [7:3] zero
    output logic                          m_tlast    // last_event
);
    import bgc_pkg::*;

    bgc_events_t ev;
    logic        ev_ready;

    // Tick register, state and event logic
    bgc_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tick_valid (s_tvalid),
        .tick_ready (s_tready),
        .tick_pin   (s_tdata[0]),
        .ev         (ev),
        .ev_ready   (ev_ready)
    );

    // Event result register and drain
    bgc_out_seq u_out_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev       (ev),
        .ev_ready (ev_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: verif/button_gesture_classifier_test.sv
// button_gesture_classifier_test: self-checking bench for the button gesture classifier.
// A queue-fed tick driver and an event monitor check the block against a local predictor.
// Depends on bgc_pkg and button_gesture_classifier.
`timescale 1ns / 1ps
module button_gesture_classifier_test;
    import bgc_pkg::*;

    localparam int AGE_W      = COUNTER_BITS_DEF;
    localparam int STALL_MAX  = 3000;
    localparam int DRAIN_WAIT = 10;

    typedef struct {
        ev_code_t code;
        logic     last;
    } gesture_event_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Block ports
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [0] pin_level, [7:1] unused
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [2:0] event_code, [7:3] zero
    logic                 m_tlast;          // last_event

    button_gesture_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Pending ticks, expected events, bench control
    logic [7:0]     tick_q [$];
    gesture_event_t pending_events [$];
    gesture_event_t want_event;
    int             fail_count    = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             stall_cycles  = 0;
    int             queued        = 0;

    // Predictor configuration (reset values)
    logic [CFG_W-1:0] long_thr = LONG_RST;
    logic [CFG_W-1:0] dbl_thr  = DOUBLE_RST;
    logic [CFG_W-1:0] arm_thr  = ARM_RST;
    logic             pol_low  = 1'b1;

    // Predictor gesture state
    logic             held          = 1'b0;
    logic             long_sent     = 1'b0;
    logic             tap_seen      = 1'b0;
    logic             second_tap    = 1'b0;
    logic             armed         = 1'b0;
    logic [AGE_W-1:0] hold_age      = '0;
    logic [AGE_W-1:0] release_age   = '0;
    logic [AGE_W-1:0] arm_age       = '0;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        return (a == '1) ? a : a + 1'b1;
    endfunction

    // Advance the gesture state by one tick and queue the events it raises
    task automatic classify_tick(input logic pin);
        logic     pressed;
        ev_code_t evs [3];
        int       n;
        pressed     = pol_low ? ~pin : pin;
        n           = 0;
        hold_age    = age_inc(hold_age);
        release_age = age_inc(release_age);
        arm_age     = age_inc(arm_age);

        // double-press window closes silently
        if (tap_seen && !pressed && release_age >= dbl_thr)
            tap_seen = 1'b0;

        // armed power-off times out
        if (armed && !pressed && arm_age >= arm_thr)
        begin
            armed  = 1'b0;
            evs[n] = EV_CANCELLED;
            n++;
        end

        if (pressed && !held)
        begin
            second_tap = tap_seen && (release_age < dbl_thr);
            armed      = 1'b0;
            hold_age   = '0;
            held       = 1'b1;
            long_sent  = 1'b0;
            evs[n]     = EV_PRESSED;
            n++;
        end
        else if (pressed && held)
        begin
            if (!long_sent && hold_age >= long_thr)
            begin
                long_sent  = 1'b1;
                second_tap = 1'b0;
                tap_seen   = 1'b0;
                evs[n]     = EV_LONG;
                n++;
            end
        end
        else if (!pressed && held)
        begin
            held = 1'b0;
            if (!long_sent)
            begin
                if (second_tap)
                begin
                    tap_seen   = 1'b0;
                    second_tap = 1'b0;
                    evs[n]     = EV_CANCELLED;
                    n++;
                    evs[n]     = EV_DOUBLE;
                    n++;
                end
                else
                begin
                    tap_seen    = 1'b1;
                    release_age = '0;
                    second_tap  = 1'b0;
                    if (!armed)
                    begin
                        armed   = 1'b1;
                        arm_age = '0;
                        evs[n]  = EV_ARMED;
                        n++;
                    end
                end
            end
            else
                second_tap = 1'b0;
            evs[n] = EV_RELEASED;
            n++;
        end

        for (int i = 0; i < n; i++)
            pending_events.push_back('{code: evs[i], last: (i == n - 1)});
    endtask

    // Tick driver: holds tvalid until the transfer, predicts on every accepted tick
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                classify_tick(s_tdata[0]);
            if (!s_tvalid || s_tready)
            begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tick_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Event monitor: compares each transfer with the oldest expected event
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("unexpected event: event_code %0d", m_tdata[2:0]);
                    fail_count++;
                end
                else
                begin
                    want_event = pending_events.pop_front();
                    if (m_tdata[2:0] !== want_event.code)
                    begin
                        $error("event_code: expected %0d, got %0d",
                               want_event.code, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tlast !== want_event.last)
                    begin
                        $error("last_event: expected %0b, got %0b", want_event.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[7:3] !== 5'd0)
                    begin
                        $error("tdata padding: expected 0, got %0h", m_tdata[7:3]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("button_gesture_classifier_test: FAIL");
            $finish;
        end
    end

    // Stimulus helpers
    task automatic add_raw(input logic pin);
        logic [6:0] junk;
        junk = 7'($urandom);
        tick_q.push_back({junk, pin});
        queued++;
    endtask

    task automatic add_ticks(input logic press, input int n);
        for (int i = 0; i < n; i++)
            add_raw(pol_low ? ~press : press);
    endtask

    function automatic int cap_of(input logic [CFG_W-1:0] thr, input int lim);
        if (thr == 0)
            return 1;
        return (thr > lim) ? lim : int'(thr);
    endfunction

    task automatic add_tap();
        add_ticks(1'b1, $urandom_range(1, cap_of(long_thr, 6)));
    endtask

    // Mostly well-formed gestures with random timing, some noise
    task automatic add_gestures(input int n_items);
        int target;
        int pick;
        target = queued + n_items;
        while (queued < target)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                add_tap();
                add_ticks(1'b0, $urandom_range(1, 6));
            end
            else if (pick < 60)
            begin
                add_tap();
                add_ticks(1'b0, $urandom_range(1, cap_of(dbl_thr, 6)));
                add_tap();
                add_ticks(1'b0, $urandom_range(1, 4));
            end
            else if (pick < 75)
            begin
                if (long_thr <= 12)
                    add_ticks(1'b1, int'(long_thr) + 1 + $urandom_range(0, 2));
                else
                    add_tap();
                add_ticks(1'b0, $urandom_range(1, 3));
            end
            else if (pick < 90)
                add_ticks(1'b0, $urandom_range(1, 12));
            else
                repeat ($urandom_range(1, 6)) add_raw(1'($urandom));
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] dp,
                              input logic [CFG_W-1:0] aw, input logic [CFG_W-1:0] pol_word);
        write_reg(CFG_LONG_PRESS, lp);
        write_reg(CFG_DOUBLE_PRESS, dp);
        write_reg(CFG_ARM_WINDOW, aw);
        write_reg(CFG_ACTIVE_LOW, pol_word);
        long_thr = lp;
        dbl_thr  = dp;
        arm_thr  = aw;
        pol_low  = pol_word[0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Sender holds off until every expected event has left and the block is quiet
    task automatic drain();
        do
            @(negedge clk);
        while (tick_q.size() != 0 || s_tvalid || pending_events.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Phases: reset defaults, short windows, zero windows, unit windows,
    // maximum windows, mid windows
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 65;
        // released at startup gives nothing; tap arms; quick second tap is a double press
        add_ticks(1'b0, 3);
        add_ticks(1'b1, 2);
        add_ticks(1'b0, 2);
        add_ticks(1'b1, 1);
        add_ticks(1'b0, 1);
        add_gestures(8);
        drain();

        // high bits of the polarity word are dropped: active high
        set_config(16'd3, 16'd4, 16'd6, 16'hFFFE);
        add_ticks(1'b1, 5);     // long press
        add_ticks(1'b0, 1);
        add_ticks(1'b1, 1);     // tap, then arm timeout and window expiry
        add_ticks(1'b0, 8);
        add_ticks(1'b1, 1);     // two taps too far apart
        add_ticks(1'b0, 5);
        add_ticks(1'b1, 1);
        add_ticks(1'b0, 1);
        add_gestures(25);
        drain();

        send_idle_pct = 65;
        recv_idle_pct = 16;
        // zero thresholds: every comparison holds at once
        set_config(16'd0, 16'd0, 16'd0, 16'h8001);
        add_ticks(1'b1, 2);
        add_ticks(1'b0, 2);
        add_ticks(1'b1, 1);
        add_ticks(1'b0, 1);
        add_gestures(12);
        drain();

        set_config(16'd1, 16'd1, 16'd1, 16'h0000);
        add_gestures(15);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
        add_gestures(14);
        drain();

        set_config(16'd4, 16'd6, 16'd9, 16'h0000);
        add_gestures(16);
        drain();

        if (fail_count == 0)
            $display("button_gesture_classifier_test: PASS");
        else
            $display("button_gesture_classifier_test: FAIL");
        $finish;
    end

endmodule
